### sv/rhmw_pkg.sv
package rhmw_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 7;
  localparam int COORD_W = 6;
  localparam int SIZE_W = 7;
  localparam int SIZE_LIMIT = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW    = 3'd5;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_STEP    = 2'd2;

  typedef enum logic [1:0] {
    HEAD_UP,
    HEAD_DOWN,
    HEAD_LEFT,
    HEAD_RIGHT
  } heading_t;

  typedef enum logic [1:0] {
    PROBE_RIGHT,
    PROBE_AHEAD,
    PROBE_LEFT
  } probe_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST_R,
    ST_TEST_A,
    ST_TEST_L,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic       load_cell;
    logic       restart;
    logic       clr_moved;
    probe_sel_t probe_sel;
    logic       set_head;
    logic       move;
    logic       load_out;
  } rhmw_cmd_t;

  typedef struct packed {
    logic at_end;
    logic probe_open;
  } rhmw_stat_t;

  function automatic heading_t turn_right(heading_t h);
    heading_t r;
    unique case (h)
      HEAD_UP:    r = HEAD_RIGHT;
      HEAD_DOWN:  r = HEAD_LEFT;
      HEAD_LEFT:  r = HEAD_UP;
      HEAD_RIGHT: r = HEAD_DOWN;
      default:    r = HEAD_RIGHT;
    endcase
    return r;
  endfunction

  function automatic heading_t turn_left(heading_t h);
    heading_t r;
    unique case (h)
      HEAD_UP:    r = HEAD_LEFT;
      HEAD_DOWN:  r = HEAD_RIGHT;
      HEAD_LEFT:  r = HEAD_DOWN;
      HEAD_RIGHT: r = HEAD_UP;
      default:    r = HEAD_LEFT;
    endcase
    return r;
  endfunction

endpackage

### sv/rhmw_in_if.sv
interface rhmw_in_if import rhmw_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [COORD_W-1:0] cell_col;
  logic [COORD_W-1:0] cell_row;
  logic               cell_is_wall;

  modport source(output valid, action, cell_col, cell_row, cell_is_wall, input ready);
  modport sink(input valid, action, cell_col, cell_row, cell_is_wall, output ready);
endinterface

### sv/rhmw_out_if.sv
interface rhmw_out_if import rhmw_pkg::*;;
  logic               valid;
  logic               ready;
  logic               moved;
  logic [1:0]         heading;
  logic               at_end;
  logic [COORD_W-1:0] pos_col;
  logic [COORD_W-1:0] pos_row;

  modport source(output valid, moved, heading, at_end, pos_col, pos_row, input ready);
  modport sink(input valid, moved, heading, at_end, pos_col, pos_row, output ready);
endinterface

### sv/rhmw_datapath.sv
module rhmw_datapath import rhmw_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [COORD_W-1:0]    cell_col,
  input  logic [COORD_W-1:0]    cell_row,
  input  logic                  cell_is_wall,
  input  rhmw_cmd_t             cmd,
  output rhmw_stat_t            stat,
  output logic                  moved,
  output logic [1:0]            heading,
  output logic                  at_end,
  output logic [COORD_W-1:0]    pos_col,
  output logic [COORD_W-1:0]    pos_row
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int LIM_C = (MAX_COLS < SIZE_LIMIT) ? MAX_COLS : SIZE_LIMIT;
  localparam int LIM_R = (MAX_ROWS < SIZE_LIMIT) ? MAX_ROWS : SIZE_LIMIT;

  logic [SIZE_W-1:0]  grid_width, grid_height;
  logic [COORD_W-1:0] start_col, start_row, goal_col, goal_row;
  logic [COORD_W-1:0] walker_col, walker_row;
  heading_t           walker_heading;
  logic               step_moved;

  logic [COORD_W-1:0] probe_col, probe_row;
  heading_t           probe_dir;
  logic               probe_in_grid;
  logic               map_rd;
  logic               map_mem [DEPTH];

  logic [SIZE_W-1:0]  used_w, used_h;
  heading_t           pdir;
  logic [SIZE_W-1:0]  nc, nr;
  logic               in_grid;
  logic [AW-1:0]      probe_addr, load_addr;
  logic               load_ok;
  logic               on_goal;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(SIZE_LIMIT);
      grid_height <= SIZE_W'(SIZE_LIMIT);
      start_col   <= '0;
      start_row   <= '0;
      goal_col    <= '0;
      goal_row    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        CFG_START_COL:   start_col   <= cfg_data[COORD_W-1:0];
        CFG_START_ROW:   start_row   <= cfg_data[COORD_W-1:0];
        CFG_GOAL_COL:    goal_col    <= cfg_data[COORD_W-1:0];
        CFG_GOAL_ROW:    goal_row    <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign used_w = (grid_width > SIZE_W'(LIM_C)) ? SIZE_W'(LIM_C) : grid_width;
  assign used_h = (grid_height > SIZE_W'(LIM_R)) ? SIZE_W'(LIM_R) : grid_height;

  always_comb begin
    unique case (cmd.probe_sel)
      PROBE_RIGHT: pdir = turn_right(walker_heading);
      PROBE_AHEAD: pdir = walker_heading;
      PROBE_LEFT:  pdir = turn_left(walker_heading);
      default:     pdir = walker_heading;
    endcase
  end

  // a step below zero wraps to 127, which is always off the grid
  always_comb begin
    nc = {1'b0, walker_col};
    nr = {1'b0, walker_row};
    unique case (pdir)
      HEAD_UP:    nr = nr - 1'b1;
      HEAD_DOWN:  nr = nr + 1'b1;
      HEAD_LEFT:  nc = nc - 1'b1;
      HEAD_RIGHT: nc = nc + 1'b1;
      default: ;
    endcase
  end

  assign in_grid    = (nc < used_w) && (nr < used_h);
  assign probe_addr = {RW'(nr), CW'(nc)};
  assign load_addr  = {RW'(cell_row), CW'(cell_col)};
  assign load_ok    = (32'(cell_col) < MAX_COLS) && (32'(cell_row) < MAX_ROWS);

  always_ff @(posedge clk) begin
    if (cmd.load_cell && load_ok) begin
      map_mem[load_addr] <= cell_is_wall;
    end else begin
      map_rd <= map_mem[probe_addr];
    end
  end

  always_ff @(posedge clk) begin
    probe_col     <= nc[COORD_W-1:0];
    probe_row     <= nr[COORD_W-1:0];
    probe_dir     <= pdir;
    probe_in_grid <= in_grid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walker_col     <= '0;
      walker_row     <= '0;
      walker_heading <= HEAD_RIGHT;
    end else if (cmd.restart) begin
      walker_col     <= start_col;
      walker_row     <= start_row;
      walker_heading <= HEAD_RIGHT;
    end else begin
      if (cmd.set_head) walker_heading <= probe_dir;
      if (cmd.move) begin
        walker_col <= probe_col;
        walker_row <= probe_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) step_moved <= 1'b0;
    else if (cmd.clr_moved) step_moved <= 1'b0;
    else if (cmd.move) step_moved <= 1'b1;
  end

  assign on_goal = (walker_col == goal_col) && (walker_row == goal_row);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      moved   <= step_moved;
      heading <= walker_heading;
      at_end  <= on_goal;
      pos_col <= walker_col;
      pos_row <= walker_row;
    end
  end

  assign stat.at_end     = on_goal;
  assign stat.probe_open = probe_in_grid && !map_rd;

endmodule

### sv/rhmw_ctrl.sv
module rhmw_ctrl import rhmw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  rhmw_stat_t stat,
  output rhmw_cmd_t  cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && action == ACT_STEP) begin
          state_next = stat.at_end ? ST_REPLY : ST_TEST_R;
        end
      end
      ST_TEST_R: state_next = stat.probe_open ? ST_REPLY : ST_TEST_A;
      ST_TEST_A: state_next = stat.probe_open ? ST_REPLY : ST_TEST_L;
      ST_TEST_L: state_next = ST_REPLY;
      ST_REPLY:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.probe_sel = PROBE_RIGHT;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_cell = in_valid && action == ACT_LOAD;
        cmd.restart   = in_valid && action == ACT_RESTART;
        cmd.clr_moved = in_valid && action == ACT_STEP;
      end
      ST_TEST_R: begin
        cmd.probe_sel = PROBE_AHEAD;
        cmd.set_head  = stat.probe_open;
        cmd.move      = stat.probe_open;
      end
      ST_TEST_A: begin
        cmd.probe_sel = PROBE_LEFT;
        cmd.move      = stat.probe_open;
      end
      ST_TEST_L: begin
        cmd.set_head = 1'b1;
        cmd.move     = stat.probe_open;
      end
      ST_REPLY: cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_move_then_reply: assert property (@(posedge clk) disable iff (rst)
    cmd.move |=> state == ST_REPLY)
    else $error("move not followed by reply");

  a_left_after_ahead: assert property (@(posedge clk) disable iff (rst)
    state == ST_TEST_L |-> $past(state) == ST_TEST_A)
    else $error("left probe out of order");

  a_reply_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPLY && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("reply lost");

endmodule

### sv/right_hand_maze_walker_unit.sv
// channel  dir  payload                                       handshake
// item     in   action, cell_col, cell_row, cell_is_wall      valid/ready
// result   out  moved, heading, at_end, pos_col, pos_row      valid/ready
// cfg      in   cfg_index, cfg_data                           cfg_we
//
// Load and restart act when accepted in idle. A step on the end cell goes
// straight to reply, else up to three neighbor probes go one per cycle
// through the single port of the wall map, then the reply loads the result.
// A step result stalled at the output holds the walker in its reply state.
// Reset clears walker, config and FSM; the wall map has no clearing pass.
module right_hand_maze_walker_unit import rhmw_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rhmw_in_if.sink               item,
  rhmw_out_if.source            result
);

  rhmw_cmd_t  cmd;
  rhmw_stat_t stat;

  rhmw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .action    (item.action),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rhmw_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cell_col     (item.cell_col),
    .cell_row     (item.cell_row),
    .cell_is_wall (item.cell_is_wall),
    .cmd          (cmd),
    .stat         (stat),
    .moved        (result.moved),
    .heading      (result.heading),
    .at_end       (result.at_end),
    .pos_col      (result.pos_col),
    .pos_row      (result.pos_row)
  );

endmodule
